[hdl/tcsc_pkg.sv]
// ----------------------------------------------------------------------------
// tcsc_pkg: shared types and constants for the timed capture split control
// Field widths, stream packing positions, mode and action codes, the
// sequencer state type and the command/status bundles.
// ----------------------------------------------------------------------------
package tcsc_pkg;

   // fixed field widths
   localparam int ACT_W   = 2;
   localparam int TS_W    = 32;
   localparam int DUR_W   = 20;
   localparam int BYTES_W = 16;
   localparam int FB_W    = 5;
   localparam int NUM_W   = 32;
   localparam int MODE_W  = 2;

   // parameter defaults
   localparam int DEF_TIME_BITS      = 32;
   localparam int DEF_BLOCK_LEN_BITS = 16;

   // request tdata packing, lowest bit first
   localparam int REQ_TS_LSB    = 0;
   localparam int REQ_DUR_LSB   = REQ_TS_LSB + TS_W;
   localparam int REQ_BYTES_LSB = REQ_DUR_LSB + DUR_W;
   localparam int REQ_FB_LSB    = REQ_BYTES_LSB + BYTES_W;
   localparam int REQ_IDX_LSB   = REQ_FB_LSB + FB_W;
   localparam int REQ_USED_W    = REQ_IDX_LSB + NUM_W;
   localparam int REQ_DATA_W    = ((REQ_USED_W + 7) / 8) * 8;

   // response tdata packing, lowest bit first
   localparam int RSP_OLD_LSB    = 0;
   localparam int RSP_CLOSE_POS  = RSP_OLD_LSB + BYTES_W;
   localparam int RSP_OPEN_POS   = RSP_CLOSE_POS + 1;
   localparam int RSP_NUM_LSB    = RSP_OPEN_POS + 1;
   localparam int RSP_NEW_LSB    = RSP_NUM_LSB + NUM_W;
   localparam int RSP_MISSED_POS = RSP_NEW_LSB + BYTES_W;
   localparam int RSP_MODE_LSB   = RSP_MISSED_POS + 1;
   localparam int RSP_USED_W     = RSP_MODE_LSB + MODE_W;
   localparam int RSP_DATA_W     = ((RSP_USED_W + 7) / 8) * 8;

   typedef enum logic [MODE_W-1:0] {
      MODE_STOPPED    = 2'd0,
      MODE_WAIT_START = 2'd1,
      MODE_WAIT_FILE  = 2'd2,
      MODE_RUNNING    = 2'd3
   } mode_type;

   typedef enum logic [ACT_W-1:0] {
      ACT_START     = 2'd0,
      ACT_BLOCK     = 2'd1,
      ACT_STOP      = 2'd2,
      ACT_SET_INDEX = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WAIT,
      ST_CHECK,
      ST_DIV_A,
      ST_MUL,
      ST_LOAD_B,
      ST_DIV_B,
      ST_SCALE,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic load;        // capture request fields
      logic calc_wait;   // target minus block time
      logic div_load_a;  // divider: length / frame size
      logic div_load_b;  // divider: product / duration
      logic div_step;    // one quotient bit
      logic mul;         // wait * frames + duration / 2
      logic scale;       // split frame to bytes, clamp
      logic finish;      // update state, load response
   } cmd_type;

   typedef struct packed {
      logic split;       // block item in a waiting mode whose wait fits
      logic dur_zero;    // duration of zero
      logic div_last;    // final divider step this cycle
      logic out_free;    // response register can take a result
   } status_type;

endpackage

[hdl/tcsc_ctrl.sv]
// ----------------------------------------------------------------------------
// tcsc_ctrl: sequencer for the timed capture split control
// Steps each request through wait calculation, the two divisions (split blocks
// only) and the final update; drives the datapath through a command bundle.
// ----------------------------------------------------------------------------
module tcsc_ctrl
   import tcsc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_WAIT;
         end
         ST_WAIT:   state_in = ST_CHECK;
         ST_CHECK: begin
            state_in = status.split ? ST_DIV_A : ST_FINISH;
         end
         ST_DIV_A: begin
            if (status.div_last) state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = status.dur_zero ? ST_SCALE : ST_LOAD_B;
         end
         ST_LOAD_B: state_in = ST_DIV_B;
         ST_DIV_B: begin
            if (status.div_last) state_in = ST_SCALE;
         end
         ST_SCALE:  state_in = ST_FINISH;
         ST_FINISH: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_WAIT:   cmd.calc_wait  = 1'b1;
         ST_CHECK:  cmd.div_load_a = status.split;
         ST_DIV_A:  cmd.div_step   = 1'b1;
         ST_MUL:    cmd.mul        = 1'b1;
         ST_LOAD_B: cmd.div_load_b = 1'b1;
         ST_DIV_B:  cmd.div_step   = 1'b1;
         ST_SCALE:  cmd.scale      = 1'b1;
         ST_FINISH: cmd.finish     = status.out_free;
         default:   cmd            = '0;
      endcase
   end

endmodule

[hdl/tcsc_datapath.sv]
// ----------------------------------------------------------------------------
// tcsc_datapath: registers and arithmetic for the timed capture split control
// Holds mode, target time and file counter, a shared restoring divider,
// the split multiplier and the response register.
// ----------------------------------------------------------------------------
module tcsc_datapath
   import tcsc_pkg::*;
#(
   parameter int TIME_BITS      = DEF_TIME_BITS,
   parameter int BLOCK_LEN_BITS = DEF_BLOCK_LEN_BITS
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [ACT_W-1:0]      req_action,
   input  logic [TS_W-1:0]       req_time_stamp,
   input  logic [DUR_W-1:0]      req_block_duration,
   input  logic [BYTES_W-1:0]    req_block_bytes,
   input  logic [FB_W-1:0]       req_frame_bytes,
   input  logic [NUM_W-1:0]      req_index_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [BYTES_W-1:0]    rsp_old_file_bytes,
   output logic                  rsp_close_old,
   output logic                  rsp_open_new,
   output logic [NUM_W-1:0]      rsp_new_file_number,
   output logic [BYTES_W-1:0]    rsp_new_file_bytes,
   output logic                  rsp_missed_start,
   output logic [MODE_W-1:0]     rsp_mode_after
);

   // usable block length, time word and compare widths
   localparam int LW    = (BLOCK_LEN_BITS < BYTES_W) ? BLOCK_LEN_BITS : BYTES_W;
   localparam int TW    = (TIME_BITS > TS_W) ? TIME_BITS : TS_W;
   localparam int CW    = (TIME_BITS > DUR_W) ? TIME_BITS : DUR_W;
   localparam int PW    = DUR_W + LW + 1;
   localparam int RW    = DUR_W;
   localparam int CNT_W = $clog2(LW + 1);

   // captured request
   action_type             action_ff;
   logic [TIME_BITS-1:0]   ts_ff;
   logic [DUR_W-1:0]       dur_ff;
   logic [LW-1:0]          len_ff;
   logic [FB_W-1:0]        fb_ff;
   logic [NUM_W-1:0]       index_ff;

   // architectural state
   mode_type               mode_ff;
   logic [TIME_BITS-1:0]   target_ff;
   logic [NUM_W-1:0]       count_ff;

   // working registers
   logic [TIME_BITS-1:0]   diff_ff;
   logic                   missed_ff;
   logic [RW-1:0]          rem_ff;
   logic [LW-1:0]          quo_ff;
   logic [RW-1:0]          divisor_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic [PW-1:0]          prod_ff;
   logic [LW-1:0]          split_ff;

   // response register
   logic                   rsp_valid_ff;
   logic [BYTES_W-1:0]     old_ff;
   logic                   close_ff;
   logic                   open_ff;
   logic [NUM_W-1:0]       num_ff;
   logic [BYTES_W-1:0]     new_ff;
   logic                   miss_out_ff;
   logic [MODE_W-1:0]      mode_out_ff;

   logic [TW-1:0]          ts_ext;
   logic [TIME_BITS-1:0]   diff_in;
   logic [CW-1:0]          wait_ext;
   logic [DUR_W-1:0]       wait_val;
   logic                   fits;
   logic                   waiting;
   logic [RW:0]            rem_sh;
   logic                   ge;
   logic [RW:0]            trial;
   logic [LW-1:0]          qv;
   logic [LW+FB_W-1:0]     scaled;

   // finish results
   mode_type               mode_in;
   logic [NUM_W-1:0]       count_in;
   logic [BYTES_W-1:0]     old_in;
   logic                   close_in;
   logic                   open_in;
   logic [NUM_W-1:0]       num_in;
   logic [BYTES_W-1:0]     new_in;
   logic                   miss_in;

   assign ts_ext   = TW'(req_time_stamp);
   assign diff_in  = target_ff - ts_ff;
   assign wait_ext = missed_ff ? '0 : CW'(diff_ff);
   assign wait_val = wait_ext[DUR_W-1:0];
   assign fits     = (wait_ext <= CW'(dur_ff));
   assign waiting  = (mode_ff == MODE_WAIT_START) || (mode_ff == MODE_WAIT_FILE);

   // restoring divider step
   assign rem_sh = {rem_ff, quo_ff[LW-1]};
   assign trial  = rem_sh - {1'b0, divisor_ff};
   assign ge     = (rem_sh >= {1'b0, divisor_ff});

   assign qv     = (dur_ff == '0) ? '0 : quo_ff;
   assign scaled = (LW+FB_W)'(qv) * (LW+FB_W)'(fb_ff);

   assign status.split    = (action_ff == ACT_BLOCK) && waiting && fits;
   assign status.dur_zero = (dur_ff == '0);
   assign status.div_last = (cnt_ff == CNT_W'(1));
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= action_type'(req_action);
         ts_ff     <= ts_ext[TIME_BITS-1:0];
         dur_ff    <= req_block_duration;
         len_ff    <= req_block_bytes[LW-1:0];
         fb_ff     <= (req_frame_bytes == '0) ? FB_W'(1) : req_frame_bytes;
         index_ff  <= req_index_value;
      end
      if (cmd.calc_wait) begin
         diff_ff   <= diff_in;
         missed_ff <= diff_in[TIME_BITS-1];
      end
      if (cmd.div_load_a) begin
         rem_ff     <= '0;
         quo_ff     <= len_ff;
         divisor_ff <= RW'(fb_ff);
         cnt_ff     <= CNT_W'(LW);
      end else if (cmd.div_load_b) begin
         // quotient fits LW bits, so the upper part is already below dur
         rem_ff     <= prod_ff[LW+RW-1:LW];
         quo_ff     <= prod_ff[LW-1:0];
         divisor_ff <= dur_ff;
         cnt_ff     <= CNT_W'(LW);
      end else if (cmd.div_step) begin
         rem_ff <= ge ? trial[RW-1:0] : rem_sh[RW-1:0];
         quo_ff <= {quo_ff[LW-2:0], ge};
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
      if (cmd.mul) begin
         prod_ff <= PW'(wait_val * quo_ff) + PW'(dur_ff >> 1);
      end
      if (cmd.scale) begin
         split_ff <= (scaled > (LW+FB_W)'(len_ff)) ? len_ff : scaled[LW-1:0];
      end
   end

   // final update of mode, counter and response
   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      old_in   = '0;
      close_in = 1'b0;
      open_in  = 1'b0;
      num_in   = '0;
      new_in   = '0;
      miss_in  = 1'b0;
      unique case (action_ff)
         ACT_START: begin
            mode_in = (mode_ff == MODE_WAIT_FILE || mode_ff == MODE_RUNNING) ?
                      MODE_WAIT_FILE : MODE_WAIT_START;
         end
         ACT_BLOCK: begin
            if (mode_ff == MODE_RUNNING) begin
               old_in = BYTES_W'(len_ff);
            end else if (waiting) begin
               miss_in = missed_ff;
               if (fits) begin
                  old_in   = (mode_ff == MODE_WAIT_FILE) ? BYTES_W'(split_ff) : '0;
                  close_in = (mode_ff == MODE_WAIT_FILE);
                  open_in  = 1'b1;
                  num_in   = count_ff;
                  count_in = count_ff + NUM_W'(1);
                  new_in   = BYTES_W'(len_ff - split_ff);
                  mode_in  = MODE_RUNNING;
               end else begin
                  old_in = (mode_ff == MODE_WAIT_FILE) ? BYTES_W'(len_ff) : '0;
               end
            end
         end
         ACT_STOP: begin
            close_in = (mode_ff == MODE_WAIT_FILE || mode_ff == MODE_RUNNING);
            mode_in  = MODE_STOPPED;
         end
         ACT_SET_INDEX: begin
            count_in = index_ff;
         end
         default: mode_in = mode_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_STOPPED;
         target_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            mode_ff  <= mode_in;
            count_ff <= count_in;
            if (action_ff == ACT_START) target_ff <= ts_ff;
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         old_ff      <= old_in;
         close_ff    <= close_in;
         open_ff     <= open_in;
         num_ff      <= num_in;
         new_ff      <= new_in;
         miss_out_ff <= miss_in;
         mode_out_ff <= mode_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_old_file_bytes  = old_ff;
   assign rsp_close_old       = close_ff;
   assign rsp_open_new        = open_ff;
   assign rsp_new_file_number = num_ff;
   assign rsp_new_file_bytes  = new_ff;
   assign rsp_missed_start    = miss_out_ff;
   assign rsp_mode_after      = mode_out_ff;

endmodule

[hdl/timed_capture_split_control.sv]
// ----------------------------------------------------------------------------
// timed_capture_split_control: recording controller with timed file split
// Tracks stopped / waiting start / waiting new file / running, and for each
// audio block works out where a new file starts and the byte split.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata (lowest bit up)                        | tuser
//  --------+-----------+----------------------------------------------+--------
//  req_    | in        | time_stamp, block_duration, block_bytes,     | action
//          |           | frame_bytes, index_value (pad to 112)        |
//  rsp_    | out       | old_file_bytes, close_old, open_new,         | -
//          |           | new_file_number, new_file_bytes,             |
//          |           | missed_start, mode_after (pad to 72)         |
//
//  One request in flight. A block that starts a file makes two passes of the
//  shared restoring divider, each of L = min(BLOCK_LEN_BITS, 16) quotient
//  bits; a zero duration skips the second pass. Every other request skips
//  the divider.
//  Reset: synchronous, clears mode, target time, file counter and rsp valid.
//  Stalls: a held rsp_tready only delays the final update; the next request
//  is still taken while a result sits in the response register.
//
module timed_capture_split_control
   import tcsc_pkg::*;
#(
   parameter int TIME_BITS      = DEF_TIME_BITS,
   parameter int BLOCK_LEN_BITS = DEF_BLOCK_LEN_BITS
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [31:0] time_stamp, [51:32] block_duration, [67:52] block_bytes,
   // [72:68] frame_bytes, [104:73] index_value, [111:105] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] action
   input  logic [ACT_W-1:0]      req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [15:0] old_file_bytes, [16] close_old, [17] open_new,
   // [49:18] new_file_number, [65:50] new_file_bytes, [66] missed_start,
   // [68:67] mode_after, [71:69] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   cmd_type    cmd;
   status_type status;

   logic [BYTES_W-1:0] old_file_bytes;
   logic               close_old;
   logic               open_new;
   logic [NUM_W-1:0]   new_file_number;
   logic [BYTES_W-1:0] new_file_bytes;
   logic               missed_start;
   logic [MODE_W-1:0]  mode_after;

   tcsc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tcsc_datapath #(
      .TIME_BITS      (TIME_BITS),
      .BLOCK_LEN_BITS (BLOCK_LEN_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_action          (req_tuser),
      .req_time_stamp      (req_tdata[REQ_TS_LSB +: TS_W]),
      .req_block_duration  (req_tdata[REQ_DUR_LSB +: DUR_W]),
      .req_block_bytes     (req_tdata[REQ_BYTES_LSB +: BYTES_W]),
      .req_frame_bytes     (req_tdata[REQ_FB_LSB +: FB_W]),
      .req_index_value     (req_tdata[REQ_IDX_LSB +: NUM_W]),
      .rsp_valid           (rsp_tvalid),
      .rsp_ready           (rsp_tready),
      .rsp_old_file_bytes  (old_file_bytes),
      .rsp_close_old       (close_old),
      .rsp_open_new        (open_new),
      .rsp_new_file_number (new_file_number),
      .rsp_new_file_bytes  (new_file_bytes),
      .rsp_missed_start    (missed_start),
      .rsp_mode_after      (mode_after)
   );

   // pack response, pad to whole bytes
   assign rsp_tdata = RSP_DATA_W'({mode_after, missed_start, new_file_bytes,
                                   new_file_number, open_new, close_old,
                                   old_file_bytes});

   // one request at a time: busy straight after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while previous one still in work");

   // a missed start clamps the wait to zero, so a file always opens
   a_missed_opens: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && missed_start) |-> open_new)
      else $error("missed start without a new file");

   // opening a file always leaves the controller running
   a_open_running: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && open_new) |-> (mode_after == MODE_RUNNING))
      else $error("new file opened but mode is not running");

   // new-file fields are zero unless a file opens
   a_new_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !open_new) |-> (new_file_bytes == '0 && new_file_number == '0))
      else $error("new file fields set without a new file");

endmodule
